// ----- rtl/core/schit_pkg.sv -----
`default_nettype none

package schit_pkg;

    // Shape selector codes
    typedef enum logic [1:0] {
        KIND_RECT   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_CIRCLE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND   = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_RADIUS = 3'd3,
        CFG_SPREAD = 3'd4
    } t_cfg_idx;

    // Per-item flags that ride along with the arithmetic
    typedef struct packed {
        t_kind kind;
        logic  box;
        logic  corner;
    } t_tag;

    // Stage enables for the squaring unit
    typedef struct packed {
        logic en_pp;
        logic en_sum;
    } t_sq_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/schit_if.sv -----
`default_nettype none

// Point channel
interface schit_pt_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// Result channel
interface schit_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

// Configuration write channel
interface schit_cfg_if #(
    parameter int DATA_W = 23
);
    logic                          valid;
    logic                          ready;
    logic [schit_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/schit_square.sv -----
`default_nettype none

// Two-stage squarer built from half-width partial products
module schit_square import schit_pkg::*; #(
    parameter int MAG_W = 26
) (
    input  wire logic               i_clk,
    input  wire t_sq_ctrl           i_ctrl,
    input  wire logic [MAG_W-1:0]   i_mag,
    output logic      [2*MAG_W-1:0] o_sq
);

    localparam int LO_W = (MAG_W + 1) / 2;
    localparam int HI_W = MAG_W - LO_W;
    localparam int SQ_W = 2 * MAG_W;

    logic [LO_W-1:0]      w_a0;
    logic [HI_W-1:0]      w_a1;
    logic [2*LO_W-1:0]    n_p00;
    logic [LO_W+HI_W-1:0] n_p01;
    logic [2*HI_W-1:0]    n_p11;
    logic [2*LO_W-1:0]    r_p00;
    logic [LO_W+HI_W-1:0] r_p01;
    logic [2*HI_W-1:0]    r_p11;
    logic [SQ_W-1:0]      n_sq;
    logic [SQ_W-1:0]      r_sq;

    assign w_a0 = i_mag[LO_W-1:0];
    assign w_a1 = i_mag[MAG_W-1:LO_W];

    // partial products
    assign n_p00 = (2*LO_W)'(w_a0) * (2*LO_W)'(w_a0);
    assign n_p01 = (LO_W+HI_W)'(w_a0) * (LO_W+HI_W)'(w_a1);
    assign n_p11 = (2*HI_W)'(w_a1) * (2*HI_W)'(w_a1);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_pp) begin
            r_p00 <= n_p00;
            r_p01 <= n_p01;
            r_p11 <= n_p11;
        end
    end

    // a^2 = a1^2 << 2L + 2*a0*a1 << L + a0^2
    assign n_sq = {r_p11, r_p00} + (SQ_W'(r_p01) << (LO_W + 1));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

`default_nettype wire

// ----- rtl/core/shape_coverage_hit_test_core.sv -----
// Point-in-shape coverage test, one local point per item.
// i_pt carries point_x/point_y (signed fixed point, COORD_WIDTH bits). o_res
// carries inside_res, one result per point, in order. i_cfg writes the shape
// registers by index (kind, width, height, radius, spread); it is always
// ready and should only be used while no item is in flight.
// Throughput: one item per clock while o_res.ready is high or a stage is
// empty; the seven register stages each hold their own item and valid bit,
// so a new point can enter in every such cycle.
// The depth is set by the squared-distance path: corner selection, a
// half-width partial-product multiply stage, a recombine stage and the
// final wide add and compare.
// Reset clears the shape registers to zero (rectangle of size 0) and
// empties the pipeline. When the receiver holds o_res.ready low, the result
// register holds and earlier stages keep filling until all stages are full;
// only then does i_pt.ready drop. Nothing is dropped or repeated.
`default_nettype none

module shape_coverage_hit_test_core import schit_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    schit_pt_if.sink     i_pt,
    schit_cfg_if.sink    i_cfg,
    schit_res_if.source  o_res
);

    localparam int RW   = COORD_WIDTH - 1;   // register width
    localparam int PW   = COORD_WIDTH + 1;   // doubled point width
    localparam int DW   = COORD_WIDTH + 3;   // signed distance width
    localparam int MW   = COORD_WIDTH + 2;   // distance magnitude width
    localparam int SW   = 2 * MW;            // square width
    localparam int NSTG = 7;

    // Shape registers
    t_kind            r_kind;
    logic [RW-1:0]    r_width;
    logic [RW-1:0]    r_height;
    logic [RW-1:0]    r_radius;
    logic [RW-1:0]    r_spread;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= KIND_RECT;
            r_width  <= '0;
            r_height <= '0;
            r_radius <= '0;
            r_spread <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_KIND:   r_kind   <= t_kind'(i_cfg.data[1:0]);
                CFG_WIDTH:  r_width  <= i_cfg.data[RW-1:0];
                CFG_HEIGHT: r_height <= i_cfg.data[RW-1:0];
                CFG_RADIUS: r_radius <= i_cfg.data[RW-1:0];
                CFG_SPREAD: r_spread <= i_cfg.data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Valid bits and per-stage enables; a stage loads when it is empty
    // or its successor moves
    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    always_comb begin
        w_en[NSTG] = o_res.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pt.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pt.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage A: box test, effective corner radius, circle center
    logic signed [PW-1:0]      n_a_px;
    logic signed [PW-1:0]      n_a_py;
    logic signed [PW-1:0]      n_a_sp;
    logic signed [PW-1:0]      n_a_xlo;
    logic signed [PW-1:0]      n_a_ylo;
    logic signed [PW-1:0]      n_a_xhi;
    logic signed [PW-1:0]      n_a_yhi;
    logic [COORD_WIDTH-1:0]    n_a_rs;
    logic [PW-1:0]             n_a_rs2;
    logic [RW-1:0]             n_a_minwh;
    logic [PW-1:0]             n_a_reff;
    logic                      n_a_box;

    assign n_a_px  = PW'(i_pt.point_x);
    assign n_a_py  = PW'(i_pt.point_y);
    assign n_a_sp  = signed'(PW'(r_spread));
    assign n_a_xlo = n_a_px + n_a_sp;
    assign n_a_ylo = n_a_py + n_a_sp;
    assign n_a_xhi = signed'(PW'(r_width)) + n_a_sp;
    assign n_a_yhi = signed'(PW'(r_height)) + n_a_sp;
    assign n_a_box = !n_a_xlo[PW-1] && !n_a_ylo[PW-1] &&
                     (n_a_px < n_a_xhi) && (n_a_py < n_a_yhi);

    // rounded radius at doubled scale: min(2*(R+S), min(W,H))
    assign n_a_rs    = COORD_WIDTH'(r_radius) + COORD_WIDTH'(r_spread);
    assign n_a_rs2   = {n_a_rs, 1'b0};
    assign n_a_minwh = (r_width < r_height) ? r_width : r_height;
    assign n_a_reff  = (n_a_rs2 < PW'(n_a_minwh)) ? n_a_rs2 : PW'(n_a_minwh);

    logic signed [COORD_WIDTH-1:0] r_a_x;
    logic signed [COORD_WIDTH-1:0] r_a_y;
    logic [PW-1:0]                 r_a_ctr;
    logic [PW-1:0]                 r_a_rad;
    t_tag                          r_a_tag;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_x          <= i_pt.point_x;
            r_a_y          <= i_pt.point_y;
            r_a_ctr        <= (r_kind == KIND_CIRCLE) ? PW'({r_radius, 1'b0}) : n_a_reff;
            r_a_rad        <= (r_kind == KIND_CIRCLE) ? n_a_rs2 : n_a_reff;
            r_a_tag.kind   <= r_kind;
            r_a_tag.box    <= n_a_box;
            r_a_tag.corner <= 1'b0;
        end
    end

    // Stage B: doubled point, far corner centers
    logic signed [PW-1:0] n_b_x2;
    logic signed [PW-1:0] n_b_y2;
    logic signed [DW-1:0] n_b_cl;

    assign n_b_x2 = {r_a_x, 1'b0};
    assign n_b_y2 = {r_a_y, 1'b0};
    assign n_b_cl = signed'(DW'(r_a_ctr));

    logic signed [DW-1:0] r_b_x;
    logic signed [DW-1:0] r_b_y;
    logic signed [DW-1:0] r_b_cl;
    logic signed [DW-1:0] r_b_wr;
    logic signed [DW-1:0] r_b_hr;
    logic [PW-1:0]        r_b_rad;
    t_tag                 r_b_tag;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_b_x   <= DW'(n_b_x2);
            r_b_y   <= DW'(n_b_y2);
            r_b_cl  <= n_b_cl;
            r_b_wr  <= signed'(DW'({r_width, 1'b0})) - n_b_cl;
            r_b_hr  <= signed'(DW'({r_height, 1'b0})) - n_b_cl;
            r_b_rad <= r_a_rad;
            r_b_tag <= r_a_tag;
        end
    end

    // Stage C: offsets to near and far centers; signs give corner flags
    logic signed [DW-1:0] r_c_dxl;
    logic signed [DW-1:0] r_c_dxr;
    logic signed [DW-1:0] r_c_dyl;
    logic signed [DW-1:0] r_c_dyr;
    logic [PW-1:0]        r_c_rad;
    t_tag                 r_c_tag;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_c_dxl <= r_b_x - r_b_cl;
            r_c_dxr <= r_b_x - r_b_wr;
            r_c_dyl <= r_b_y - r_b_cl;
            r_c_dyr <= r_b_y - r_b_hr;
            r_c_rad <= r_b_rad;
            r_c_tag <= r_b_tag;
        end
    end

    // Stage D: corner pick in order top-left, top-right, bottom-right,
    // bottom-left, then magnitudes
    logic                 n_d_xl;
    logic                 n_d_xr;
    logic                 n_d_yl;
    logic                 n_d_yr;
    logic                 n_d_tl;
    logic                 n_d_tr;
    logic                 n_d_br;
    logic                 n_d_bl;
    logic signed [DW-1:0] n_d_dx;
    logic signed [DW-1:0] n_d_dy;
    logic signed [DW-1:0] n_d_ax;
    logic signed [DW-1:0] n_d_ay;

    assign n_d_xl = r_c_dxl[DW-1];
    assign n_d_yl = r_c_dyl[DW-1];
    assign n_d_xr = !r_c_dxr[DW-1] && (|r_c_dxr);
    assign n_d_yr = !r_c_dyr[DW-1] && (|r_c_dyr);
    assign n_d_tl = n_d_xl && n_d_yl;
    assign n_d_tr = n_d_xr && n_d_yl;
    assign n_d_br = n_d_xr && n_d_yr;
    assign n_d_bl = n_d_xl && n_d_yr;

    always_comb begin
        priority if (r_c_tag.kind == KIND_CIRCLE || n_d_tl) begin
            n_d_dx = r_c_dxl;
            n_d_dy = r_c_dyl;
        end else if (n_d_tr) begin
            n_d_dx = r_c_dxr;
            n_d_dy = r_c_dyl;
        end else if (n_d_br) begin
            n_d_dx = r_c_dxr;
            n_d_dy = r_c_dyr;
        end else if (n_d_bl) begin
            n_d_dx = r_c_dxl;
            n_d_dy = r_c_dyr;
        end else begin
            n_d_dx = r_c_dxl;
            n_d_dy = r_c_dyl;
        end
    end

    assign n_d_ax = n_d_dx[DW-1] ? -n_d_dx : n_d_dx;
    assign n_d_ay = n_d_dy[DW-1] ? -n_d_dy : n_d_dy;

    logic [MW-1:0] r_d_mx;
    logic [MW-1:0] r_d_my;
    logic [MW-1:0] r_d_mr;
    t_tag          r_d_tag;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_d_mx         <= n_d_ax[MW-1:0];
            r_d_my         <= n_d_ay[MW-1:0];
            r_d_mr         <= MW'(r_c_rad);
            r_d_tag.kind   <= r_c_tag.kind;
            r_d_tag.box    <= r_c_tag.box;
            r_d_tag.corner <= n_d_tl || n_d_tr || n_d_br || n_d_bl;
        end
    end

    // Stages E and F: squares of dx, dy and the radius
    t_sq_ctrl      w_sq_ctrl;
    logic [SW-1:0] w_sq_x;
    logic [SW-1:0] w_sq_y;
    logic [SW-1:0] w_sq_r;

    assign w_sq_ctrl.en_pp  = w_en[4];
    assign w_sq_ctrl.en_sum = w_en[5];

    schit_square #(.MAG_W(MW)) u_sq_x (
        .i_clk  (i_clk),
        .i_ctrl (w_sq_ctrl),
        .i_mag  (r_d_mx),
        .o_sq   (w_sq_x)
    );

    schit_square #(.MAG_W(MW)) u_sq_y (
        .i_clk  (i_clk),
        .i_ctrl (w_sq_ctrl),
        .i_mag  (r_d_my),
        .o_sq   (w_sq_y)
    );

    schit_square #(.MAG_W(MW)) u_sq_r (
        .i_clk  (i_clk),
        .i_ctrl (w_sq_ctrl),
        .i_mag  (r_d_mr),
        .o_sq   (w_sq_r)
    );

    t_tag r_e_tag;
    t_tag r_f_tag;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_e_tag <= r_d_tag;
        end
        if (w_en[5]) begin
            r_f_tag <= r_e_tag;
        end
    end

    // Stage G: distance compare and final decision into the result register
    logic [SW:0] n_g_sum;
    logic        n_g_lt;
    logic        n_g_le;
    logic        n_g_hit;

    assign n_g_sum = (SW+1)'(w_sq_x) + (SW+1)'(w_sq_y);
    assign n_g_lt  = n_g_sum < (SW+1)'(w_sq_r);
    assign n_g_le  = n_g_sum <= (SW+1)'(w_sq_r);

    always_comb begin
        unique case (r_f_tag.kind)
            KIND_RECT:   n_g_hit = r_f_tag.box;
            KIND_ROUND:  n_g_hit = r_f_tag.box && (!r_f_tag.corner || n_g_lt);
            KIND_CIRCLE: n_g_hit = n_g_le;
            KIND_NONE:   n_g_hit = 1'b0;
            default:     n_g_hit = 1'b0;
        endcase
    end

    logic r_g_hit;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_g_hit <= n_g_hit;
        end
    end

    assign o_res.valid      = r_v[NSTG-1];
    assign o_res.inside_res = r_g_hit;

    // Checks
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !o_res.ready) |-> !i_pt.ready)
        else $error("input taken while every stage is full and stalled");

    a_empty_head_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> i_pt.ready)
        else $error("first stage empty but input not ready");

    a_radius_half_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && r_b_tag.kind == KIND_ROUND) |->
            (r_b_wr >= r_b_cl && r_b_hr >= r_b_cl))
        else $error("rounded corner radius exceeds half of a side");

    a_one_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[2] && r_c_tag.kind == KIND_ROUND) |->
            $onehot0({n_d_tl, n_d_tr, n_d_br, n_d_bl}))
        else $error("point falls in more than one corner square");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_g_hit) && r_v[NSTG-1])
        else $error("stalled result changed");

endmodule

`default_nettype wire
